[sv/rsc_pkg.sv]
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int AZ_W      = 12;
  localparam int RANGE_W   = 16;
  localparam int BIN_W     = 9;
  localparam int INT_W     = 8;
  localparam int COORD_W   = 17;
  localparam int RB_W      = RANGE_W + BIN_W;
  localparam int MAG_W     = 16;
  localparam int CIRCLE_W  = 12;
  localparam int QUARTER   = 1024;
  localparam int LUT_DEPTH = QUARTER + 1;
  localparam int LUT_AW    = $clog2(LUT_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

  localparam logic [AZ_W-1:0]  ORIENT_RESET = 12'd3072;
  localparam logic [INT_W-1:0] THRESH_RESET = 8'd1;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] ONE_Q15 = 64'd32768;

  // ceil(2^64 / ((2n) * (2n + 1))), exact floor division for the series terms
  localparam logic [127:0] TWO_POW_64 = 128'd1 << 64;
  localparam logic [127:0] RCP_6   = (TWO_POW_64 + 128'd5) / 128'd6;
  localparam logic [127:0] RCP_20  = (TWO_POW_64 + 128'd19) / 128'd20;
  localparam logic [127:0] RCP_42  = (TWO_POW_64 + 128'd41) / 128'd42;
  localparam logic [127:0] RCP_72  = (TWO_POW_64 + 128'd71) / 128'd72;
  localparam logic [127:0] RCP_110 = (TWO_POW_64 + 128'd109) / 128'd110;
  localparam logic [127:0] RCP_156 = (TWO_POW_64 + 128'd155) / 128'd156;
  localparam logic [127:0] RCP_210 = (TWO_POW_64 + 128'd209) / 128'd210;
  localparam logic [127:0] RCP_272 = (TWO_POW_64 + 128'd271) / 128'd272;
  localparam logic [127:0] RCP_342 = (TWO_POW_64 + 128'd341) / 128'd342;
  localparam logic [127:0] RCP_420 = (TWO_POW_64 + 128'd419) / 128'd420;
  localparam logic [127:0] TAYLOR_RCP [10] = '{RCP_6, RCP_20, RCP_42, RCP_72, RCP_110,
                                               RCP_156, RCP_210, RCP_272, RCP_342, RCP_420};

  typedef logic [MAG_W-1:0] sine_lut_t [LUT_DEPTH];

  // quarter-wave sine, Q1.15, Taylor series in Q30 evaluated at elaboration
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t    lut;
    logic [63:0]  theta;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  rnd;
    logic [127:0] wide;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      theta = (64'(k) * PI_Q30) >> 11;
      term  = theta;
      sum   = theta;
      for (int n = 1; n <= 10; n++) begin
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        wide = 128'(term) * TAYLOR_RCP[n-1];
        term = wide[127:64];
        if (n[0]) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      rnd = (sum + 64'd16384) >> 15;
      if (rnd > ONE_Q15) begin
        rnd = ONE_Q15;
      end
      lut[k] = MAG_W'(rnd);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

[sv/rsc_spoke_if.sv]
`timescale 1ns / 1ps

interface rsc_spoke_if;
  logic                         valid;
  logic                         ready;
  logic [rsc_pkg::AZ_W-1:0]     azimuth;
  logic [rsc_pkg::RANGE_W-1:0]  spoke_range;
  logic [rsc_pkg::BIN_W-1:0]    bin_index;
  logic [rsc_pkg::INT_W-1:0]    sample_intensity;

  modport source (output valid, azimuth, spoke_range, bin_index, sample_intensity,
                  input ready);
  modport sink (input valid, azimuth, spoke_range, bin_index, sample_intensity,
                output ready);
endinterface

[sv/rsc_point_if.sv]
`timescale 1ns / 1ps

interface rsc_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [rsc_pkg::COORD_W-1:0] point_x;
  logic signed [rsc_pkg::COORD_W-1:0] point_y;
  logic [rsc_pkg::INT_W-1:0]          point_intensity;
  logic                               sweep_end;

  modport source (output valid, point_x, point_y, point_intensity, sweep_end,
                  input ready);
  modport sink (input valid, point_x, point_y, point_intensity, sweep_end,
                output ready);
endinterface

[sv/rsc_sine_rom.sv]
`timescale 1ns / 1ps

module rsc_sine_rom (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rsc_pkg::LUT_AW-1:0] addr_i,
  output logic [rsc_pkg::MAG_W-1:0]  mag_o
);
  import rsc_pkg::*;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= SINE_LUT[addr_i];
    end
  end

endmodule

[sv/radar_spoke_to_cartesian.sv]
`timescale 1ns / 1ps
// Radar spoke to Cartesian scan converter.
// Input channel spoke_i carries one radar bin per word: azimuth, spoke range,
// bin index and intensity. Output channel point_o carries one point per word
// (x, y, intensity) or a sweep-end marker (sweep_end high, all else zero).
// Both channels transfer a word when valid and ready are high at a clock edge.
// Registers are written over cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must
// do so only while idle, the block does not enforce it. Index 0 orientation offset,
// index 1 intensity threshold. A converted bin runs through one shared
// multiplier under a sequencer; a new bin waits until the last leaves S_WRITE.
// Each bin needs two reciprocal divisions for the angle, one range product and
// two (multiply, reciprocal divide) passes for x and y, one multiply a cycle.
// A marker goes straight from S_IDLE to S_WRITE, then to the output register;
// a dropped bin keeps the state in S_IDLE. The sine table is a registered ROM.
// A finished word sits in the output register; while the receiver stalls the
// next bin is still taken and computed, and waits there for the register.
// Reset clears the rotation state and the output valid flag, and restores the
// registers to their defaults (offset 3072, threshold 1).
module radar_spoke_to_cartesian #(
  parameter int BINS_PER_SPOKE = 512,
  parameter int AZIMUTH_COUNTS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  rsc_spoke_if.sink                     spoke_i,
  rsc_point_if.source                   point_o
);
  import rsc_pkg::*;

  localparam int DIV     = BINS_PER_SPOKE - 1;
  localparam logic [31:0] RECIP_D = 32'((64'd1 << 31) / DIV);
  localparam logic [31:0] RECIP_C = 32'((64'd1 << 32) / AZIMUTH_COUNTS);
  localparam int KWRAP   = (4096 + AZIMUTH_COUNTS - 1) / AZIMUTH_COUNTS;
  localparam int KC      = KWRAP * AZIMUTH_COUNTS;
  localparam int X_W     = $clog2(KC + 4096);
  localparam int D_W     = $clog2(AZIMUTH_COUNTS);
  localparam int DP_W    = D_W + CIRCLE_W;
  localparam int MA_W    = (DP_W > RB_W) ? DP_W : RB_W;
  localparam int MB_W    = 32;
  localparam int P_W     = MA_W + MB_W;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ANG_Q = 13'b0000000000010,
    S_ANG_R = 13'b0000000000100,
    S_ANG_C = 13'b0000000001000,
    S_P_Q   = 13'b0000000010000,
    S_P_R   = 13'b0000000100000,
    S_P_C   = 13'b0000001000000,
    S_ROM   = 13'b0000010000000,
    S_CM    = 13'b0000100000000,
    S_CQ    = 13'b0001000000000,
    S_CR    = 13'b0010000000000,
    S_CC    = 13'b0100000000000,
    S_WRITE = 13'b1000000000000
  } state_e;

  function automatic logic [LUT_AW-1:0] quad_index(logic [CIRCLE_W-1:0] p);
    logic [9:0] r;
    r = p[9:0];
    return p[10] ? (LUT_AW'(QUARTER) - LUT_AW'(r)) : LUT_AW'(r);
  endfunction

  state_e               state_q, state_d;
  logic [AZ_W-1:0]      orient_q;
  logic [INT_W-1:0]     thresh_q;
  logic [AZ_W-1:0]      rot_acc_q;
  logic                 spoke_on_q;
  logic                 marker_q;
  logic                 sel_q;
  logic                 out_valid_q;

  logic [RANGE_W-1:0]   range_q;
  logic [BIN_W-1:0]     bin_q;
  logic [INT_W-1:0]     int_q;
  logic [X_W-1:0]       x_q;
  logic [D_W-1:0]       d_q;
  logic [CIRCLE_W-1:0]  p_q;
  logic [RB_W-1:0]      rb_q;
  logic [RB_W-1:0]      n_q;
  logic [RB_W-1:0]      q_q;
  logic [COORD_W-1:0]   mag_x_q;
  logic [COORD_W-1:0]   mag_y_q;
  logic [P_W-1:0]       prod_q;
  logic [COORD_W-1:0]   out_x_q;
  logic [COORD_W-1:0]   out_y_q;
  logic [INT_W-1:0]     out_int_q;
  logic                 out_end_q;

  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic                 rom_en;
  logic [LUT_AW-1:0]    rom_addr;
  logic [MAG_W-1:0]     rom_mag;

  logic                 accept;
  logic                 bin0;
  logic                 wrap_ok;
  logic                 go_on;
  logic                 out_free;
  logic [CIRCLE_W-1:0]  p_cos;
  logic [X_W-1:0]       rem_x;
  logic [D_W-1:0]       d_now;
  logic [DP_W-1:0]      rem_p;
  logic [RB_W-1:0]      n_now;
  logic [RB_W-1:0]      q0_now;
  logic [RB_W-1:0]      rem_n;
  logic [RB_W-1:0]      q_fix;

  rsc_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (rom_en),
    .addr_i (rom_addr),
    .mag_o  (rom_mag)
  );

  assign spoke_i.ready = (state_q == S_IDLE);
  assign accept        = spoke_i.valid && spoke_i.ready;
  assign bin0          = (spoke_i.bin_index == '0);
  assign wrap_ok       = (spoke_i.azimuth >= rot_acc_q) &&
                         (32'(spoke_i.azimuth) < AZIMUTH_COUNTS);
  assign go_on         = (bin0 || spoke_on_q) &&
                         (32'(spoke_i.bin_index) < BINS_PER_SPOKE) &&
                         (spoke_i.sample_intensity >= thresh_q);
  assign out_free      = !out_valid_q || point_o.ready;

  assign p_cos  = p_q + CIRCLE_W'(QUARTER);
  assign rem_x  = x_q - X_W'(prod_q);
  assign d_now  = (32'(rem_x) >= AZIMUTH_COUNTS) ? D_W'(32'(rem_x) - AZIMUTH_COUNTS)
                                                 : D_W'(rem_x);
  assign rem_p  = {d_q, {CIRCLE_W{1'b0}}} - DP_W'(prod_q);
  assign n_now  = RB_W'(prod_q >> 15);
  assign q0_now = RB_W'(prod_q >> 31);
  assign rem_n  = n_q - RB_W'(prod_q);
  assign q_fix  = (32'(rem_n) >= DIV) ? q_q + RB_W'(1) : q_q;

  always_comb begin
    state_d  = state_q;
    mul_a    = '0;
    mul_b    = '0;
    rom_en   = 1'b0;
    rom_addr = quad_index(p_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (bin0 && !wrap_ok) begin
            state_d = S_WRITE;
          end else if (go_on) begin
            state_d = S_ANG_Q;
          end
        end
      end
      S_ANG_Q: begin
        mul_a   = MA_W'(x_q);
        mul_b   = RECIP_C;
        state_d = S_ANG_R;
      end
      S_ANG_R: begin
        mul_a   = MA_W'(prod_q >> 32);
        mul_b   = MB_W'(AZIMUTH_COUNTS);
        state_d = S_ANG_C;
      end
      S_ANG_C: begin
        mul_a   = MA_W'(range_q);
        mul_b   = MB_W'(bin_q);
        state_d = S_P_Q;
      end
      S_P_Q: begin
        mul_a   = MA_W'({d_q, {CIRCLE_W{1'b0}}});
        mul_b   = RECIP_C;
        state_d = S_P_R;
      end
      S_P_R: begin
        mul_a   = MA_W'(prod_q >> 32);
        mul_b   = MB_W'(AZIMUTH_COUNTS);
        state_d = S_P_C;
      end
      S_P_C: begin
        state_d = S_ROM;
      end
      S_ROM: begin
        rom_en  = 1'b1;
        state_d = S_CM;
      end
      S_CM: begin
        mul_a    = MA_W'(rb_q);
        mul_b    = MB_W'(rom_mag);
        rom_en   = !sel_q;
        rom_addr = quad_index(p_cos);
        state_d  = S_CQ;
      end
      S_CQ: begin
        mul_a   = MA_W'(n_now);
        mul_b   = RECIP_D;
        state_d = S_CR;
      end
      S_CR: begin
        mul_a   = MA_W'(q0_now);
        mul_b   = MB_W'(DIV);
        state_d = S_CC;
      end
      S_CC: begin
        state_d = sel_q ? S_WRITE : S_CM;
      end
      S_WRITE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      orient_q    <= ORIENT_RESET;
      thresh_q    <= THRESH_RESET;
      rot_acc_q   <= '0;
      spoke_on_q  <= 1'b0;
      marker_q    <= 1'b0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIENT: orient_q <= cfg_wdata_i[AZ_W-1:0];
          CFG_THRESH: thresh_q <= cfg_wdata_i[INT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        marker_q <= bin0 && !wrap_ok;
        if (bin0) begin
          rot_acc_q  <= wrap_ok ? spoke_i.azimuth : '0;
          spoke_on_q <= wrap_ok;
        end
      end
      if (state_q == S_ROM) begin
        sel_q <= 1'b0;
      end else if (state_q == S_CC) begin
        sel_q <= 1'b1;
      end
      if (state_q == S_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (point_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          range_q <= spoke_i.spoke_range;
          bin_q   <= spoke_i.bin_index;
          int_q   <= spoke_i.sample_intensity;
          x_q     <= X_W'(spoke_i.azimuth) + X_W'(KC) - X_W'(orient_q);
        end
      end
      S_ANG_C: d_q  <= d_now;
      S_P_Q:   rb_q <= RB_W'(prod_q);
      S_P_R:   p_q  <= CIRCLE_W'(prod_q >> 32);
      S_P_C: begin
        if (32'(rem_p) >= AZIMUTH_COUNTS) begin
          p_q <= p_q + CIRCLE_W'(1);
        end
      end
      S_CQ: n_q <= n_now;
      S_CR: q_q <= q0_now;
      S_CC: begin
        if (sel_q) begin
          mag_y_q <= COORD_W'(q_fix);
        end else begin
          mag_x_q <= COORD_W'(q_fix);
        end
      end
      S_WRITE: begin
        if (out_free) begin
          if (marker_q) begin
            out_x_q   <= '0;
            out_y_q   <= '0;
            out_int_q <= '0;
            out_end_q <= 1'b1;
          end else begin
            out_x_q   <= p_q[CIRCLE_W-1] ? COORD_W'(0) - mag_x_q : mag_x_q;
            out_y_q   <= p_cos[CIRCLE_W-1] ? COORD_W'(0) - mag_y_q : mag_y_q;
            out_int_q <= int_q;
            out_end_q <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign point_o.valid           = out_valid_q;
  assign point_o.point_x         = $signed(out_x_q);
  assign point_o.point_y         = $signed(out_y_q);
  assign point_o.point_intensity = out_int_q;
  assign point_o.sweep_end       = out_end_q;

  a_marker_path : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && bin0 && !wrap_ok) |=> (state_q == S_WRITE && marker_q))
    else $error("wrapped spoke did not raise a marker");

  a_write_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished word not moved to output register");

  a_angle_fix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P_C) |-> (32'(rem_p) < 2 * AZIMUTH_COUNTS))
    else $error("angle reciprocal estimate off by more than one");

  a_coord_fix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CC) |-> (32'(rem_n) < 2 * DIV))
    else $error("range reciprocal estimate off by more than one");

  a_marker_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_end_q) |-> (out_x_q == '0 && out_y_q == '0 && out_int_q == '0))
    else $error("sweep-end marker carries nonzero payload");

endmodule

[test/tb_radar_spoke_to_cartesian.sv]
`timescale 1ns / 1ps

module tb_radar_spoke_to_cartesian;
  import rsc_pkg::*;

  localparam int BINS        = 512;
  localparam int AZ_COUNTS   = 4096;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [63:0] PI_Q30_TB   = 64'd3373259426;
  localparam logic [63:0] UNITY_Q15   = 64'd32768;
  localparam logic [63:0] COORD_DENOM = 64'(BINS - 1) * UNITY_Q15;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INT_W-1:0]   intensity;
    logic               sweep_end;
  } point_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rsc_spoke_if spoke_if ();
  rsc_point_if point_if ();

  radar_spoke_to_cartesian #(
    .BINS_PER_SPOKE(BINS),
    .AZIMUTH_COUNTS(AZ_COUNTS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .spoke_i    (spoke_if),
    .point_o    (point_if)
  );

  // predictor state
  logic [15:0]      sine_q15 [0:QUARTER];
  logic [AZ_W-1:0]  orient;
  logic [INT_W-1:0] thresh;
  logic [AZ_W-1:0]  rot_acc;
  logic             in_spoke;

  point_word_t points_due [$];
  point_word_t due;

  bit steady;
  int errors = 0;
  int cycle_count = 0;
  int bins_sent = 0;
  int words_predicted = 0;
  int points_seen = 0;
  int markers_seen = 0;
  int reg_writes = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d words still due", $time, cycle_count,
               points_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    point_if.ready <= steady || ($urandom_range(99) >= 10);
  end

  // Q1.15 quarter-wave sine, Taylor series in Q30
  task automatic build_sine_q15();
    logic [63:0] ang;
    logic [63:0] term;
    logic [63:0] acc;
    for (int k = 0; k <= QUARTER; k++) begin
      ang  = (64'(k) * PI_Q30_TB) / 64'd2048;
      term = ang;
      acc  = ang;
      for (int n = 1; n <= 10; n++) begin
        term = (term * ang) >> 30;
        term = (term * ang) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = (acc >= term) ? acc - term : 64'd0;
        end else begin
          acc = acc + term;
        end
      end
      acc = (acc + 64'd16384) >> 15;
      sine_q15[k] = (acc > UNITY_Q15) ? 16'(UNITY_Q15) : acc[15:0];
    end
  endtask

  function automatic logic [COORD_W-1:0] scaled_coord(input logic [RANGE_W-1:0] rng,
                                                     input logic [BIN_W-1:0] bin,
                                                     input logic [CIRCLE_W-1:0] ang);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = 64'(sine_q15[ang[10] ? (QUARTER - int'(ang[9:0])) : int'(ang[9:0])]);
    prod = (64'(rng) * 64'(bin) * mag) / COORD_DENOM;
    if (ang[11]) begin
      prod = 64'd0 - prod;
    end
    return prod[COORD_W-1:0];
  endfunction

  task automatic predict_bin(input logic [AZ_W-1:0] az, input logic [RANGE_W-1:0] rng,
                             input logic [BIN_W-1:0] bin, input logic [INT_W-1:0] inten);
    point_word_t pt;
    logic [CIRCLE_W-1:0] ang;
    if (bin == '0) begin
      if (az >= rot_acc) begin
        rot_acc  = az;
        in_spoke = 1'b1;
      end else begin
        rot_acc  = '0;
        in_spoke = 1'b0;
        pt = '{x: '0, y: '0, intensity: '0, sweep_end: 1'b1};
        points_due = {points_due, pt};
        words_predicted++;
        return;
      end
    end
    if (!in_spoke || inten < thresh) begin
      return;
    end
    ang = az - orient;
    pt.x         = scaled_coord(rng, bin, ang);
    pt.y         = scaled_coord(rng, bin, ang + CIRCLE_W'(QUARTER));
    pt.intensity = inten;
    pt.sweep_end = 1'b0;
    points_due = {points_due, pt};
    words_predicted++;
  endtask

  always @(posedge clk) begin
    if (rst_n && point_if.valid && point_if.ready) begin
      if (points_due.size() == 0) begin
        $display("%0t unexpected word: x=%0d y=%0d intensity=%0d sweep_end=%0b", $time,
                 point_if.point_x, point_if.point_y, point_if.point_intensity,
                 point_if.sweep_end);
        errors++;
      end else begin
        due = points_due.pop_front();
        if (due.sweep_end) markers_seen++;
        else points_seen++;
        if (point_if.point_x !== due.x) begin
          $display("%0t point_x: expected %0d, got %0d", $time, $signed(due.x),
                   point_if.point_x);
          errors++;
        end
        if (point_if.point_y !== due.y) begin
          $display("%0t point_y: expected %0d, got %0d", $time, $signed(due.y),
                   point_if.point_y);
          errors++;
        end
        if (point_if.point_intensity !== due.intensity) begin
          $display("%0t point_intensity: expected %0d, got %0d", $time, due.intensity,
                   point_if.point_intensity);
          errors++;
        end
        if (point_if.sweep_end !== due.sweep_end) begin
          $display("%0t sweep_end: expected %0b, got %0b", $time, due.sweep_end,
                   point_if.sweep_end);
          errors++;
        end
      end
    end
  end

  task automatic send_bin(input logic [AZ_W-1:0] az, input logic [RANGE_W-1:0] rng,
                          input logic [BIN_W-1:0] bin, input logic [INT_W-1:0] inten);
    if (!steady && $urandom_range(99) < 10) begin
      spoke_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    spoke_if.valid            <= 1'b1;
    spoke_if.azimuth          <= az;
    spoke_if.spoke_range      <= rng;
    spoke_if.bin_index        <= bin;
    spoke_if.sample_intensity <= inten;
    @(posedge clk);
    while (!spoke_if.ready) @(posedge clk);
    predict_bin(az, rng, bin, inten);
    bins_sent++;
  endtask

  // stop sending, drain every due word, then wait out the settle time
  task automatic quiesce();
    spoke_if.valid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ORIENT: orient = data[AZ_W-1:0];
      CFG_THRESH: thresh = data[INT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic test_start_of_sweep();
    send_bin(12'd0, 16'd1000, 9'd5, 8'd50);
    send_bin(12'd0, 16'hFFFF, 9'd0, 8'd255);
    send_bin(12'd0, 16'hFFFF, 9'd511, 8'd255);
    send_bin(12'd0, 16'hFFFF, 9'd1, 8'd0);
    send_bin(12'd0, 16'd0, 9'd511, 8'd128);
  endtask

  task automatic test_sweep_wrap();
    send_bin(12'd4095, 16'd12345, 9'd0, 8'd1);
    send_bin(12'd4095, 16'd12345, 9'd300, 8'd1);
    send_bin(12'd4095, 16'd12345, 9'd0, 8'd77);
    send_bin(12'd10, 16'd4000, 9'd0, 8'd90);
    send_bin(12'd10, 16'd4000, 9'd7, 8'd200);
    send_bin(12'd0, 16'd4000, 9'd0, 8'd90);
  endtask

  task automatic test_orientation();
    quiesce();
    write_reg(CFG_ORIENT, 12'd0);
    send_bin(12'd0, 16'hFFFF, 9'd0, 8'd10);
    send_bin(12'd1023, 16'hFFFF, 9'd511, 8'd10);
    send_bin(12'd1024, 16'hFFFF, 9'd511, 8'd10);
    send_bin(12'd2048, 16'hFFFF, 9'd511, 8'd10);
    send_bin(12'd3072, 16'hFFFF, 9'd511, 8'd10);
    send_bin(12'd4095, 16'hFFFF, 9'd511, 8'd10);
    quiesce();
    write_reg(CFG_ORIENT, 12'hFFF);
    send_bin(12'd0, 16'hAAAA, 9'd257, 8'd10);
    send_bin(12'd2047, 16'h5555, 9'd170, 8'd10);
  endtask

  task automatic test_threshold();
    quiesce();
    write_reg(CFG_THRESH, 12'd0);
    send_bin(12'd300, 16'd999, 9'd3, 8'd0);
    quiesce();
    write_reg(CFG_THRESH, 12'hFFF);
    send_bin(12'd300, 16'd999, 9'd4, 8'd254);
    send_bin(12'd300, 16'd999, 9'd5, 8'd255);
  endtask

  task automatic test_register_index();
    quiesce();
    write_reg(CFG_SPARE_A, 12'hABC);
    write_reg(CFG_SPARE_B, 12'h000);
    send_bin(12'd512, 16'd3000, 9'd100, 8'd255);
  endtask

  task automatic test_random_sweeps();
    logic [AZ_W-1:0]  sweep_az;
    logic [AZ_W-1:0]  az;
    logic [RANGE_W-1:0] rng;
    logic [INT_W-1:0] hot;
    int target;
    int start;
    int sent;
    int nbins;
    sweep_az = '0;
    for (int phase = 0; phase < 8; phase++) begin
      quiesce();
      target = 75;
      case (phase)
        0: begin
          write_reg(CFG_ORIENT, 12'd0);
          write_reg(CFG_THRESH, 12'd0);
        end
        1: begin
          write_reg(CFG_ORIENT, 12'd4095);
          write_reg(CFG_THRESH, {4'hF, 8'd255});
          target = 30;
        end
        2: begin
          write_reg(CFG_ORIENT, 12'd3072);
          write_reg(CFG_THRESH, 12'd1);
        end
        default: begin
          write_reg(CFG_ORIENT, CFG_DATA_W'($urandom));
          write_reg(CFG_THRESH, {4'($urandom), ($urandom_range(3) == 0) ?
                                 8'($urandom) : 8'($urandom_range(0, 32))});
        end
      endcase
      steady = (phase == 2);
      start = words_predicted;
      sent = 0;
      while (words_predicted - start < target && sent < 4 * target) begin
        if ($urandom_range(99) < 8) begin
          send_bin(AZ_W'($urandom), RANGE_W'($urandom), BIN_W'($urandom), INT_W'($urandom));
          sent++;
        end else begin
          az    = sweep_az + (($urandom_range(9) == 0) ? AZ_W'($urandom)
                                                       : AZ_W'($urandom_range(0, 200)));
          rng   = RANGE_W'($urandom);
          nbins = $urandom_range(1, 6);
          hot   = ($urandom_range(7) == 0) ? 8'd255 : INT_W'($urandom);
          send_bin(az, rng, '0, hot);
          sent++;
          for (int j = 1; j <= nbins; j++) begin
            hot = ($urandom_range(7) == 0) ? 8'd255 : INT_W'($urandom);
            send_bin(az, rng, ($urandom_range(3) == 0) ? BIN_W'($urandom_range(1, 511))
                                                       : BIN_W'(j), hot);
            sent++;
          end
          sweep_az = az;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    spoke_if.valid = 1'b0;
    spoke_if.azimuth = '0;
    spoke_if.spoke_range = '0;
    spoke_if.bin_index = '0;
    spoke_if.sample_intensity = '0;
    point_if.ready = 1'b0;
    steady = 1'b0;
    orient = ORIENT_RESET;
    thresh = THRESH_RESET;
    rot_acc = '0;
    in_spoke = 1'b0;
    build_sine_q15();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_start_of_sweep();
    test_sweep_wrap();
    test_orientation();
    test_threshold();
    test_register_index();
    test_random_sweeps();

    spoke_if.valid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bins over several offset/threshold settings; checked %0d points",
             bins_sent, points_seen);
    $display("and %0d sweep-end markers after %0d register writes.", markers_seen,
             reg_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[radar_spoke_to_cartesian.f]
sv/rsc_pkg.sv
sv/rsc_spoke_if.sv
sv/rsc_point_if.sv
sv/rsc_sine_rom.sv
sv/radar_spoke_to_cartesian.sv
test/tb_radar_spoke_to_cartesian.sv
